>>> rtl/h4e_pkg.sv
// Package for the four-axis Hilbert index encoder.
// Field widths and default geometry shared by all rtl files; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package h4e_pkg;
  localparam int COORD_W = 16;
  localparam int INDEX_W = 64;
  localparam int MAX_AXES = 4;
  localparam int BITS_PER_AXIS_DEF = 16;
  localparam int NUM_AXES_DEF = 4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [INDEX_W-1:0] index_t;
endpackage
`default_nettype wire

>>> rtl/hilbert_4d_encode_core.sv
// Four-axis Hilbert index encoder: a chain of level cells and a finishing cell.
// Depends on h4e_pkg, h4e_level_cell and h4e_finish_cell.
// Cells: one level cell per bit level from the top down to level 1, then the
// Gray, mask and interleave cell.
// Throughput: one transaction per cycle unless index_stall holds the chain; each cell holds one point.
// Reset: synchronous rst empties every cell; no other state.
`timescale 1ns / 1ps
`default_nettype none
module hilbert_4d_encode_core #(
  parameter int BITS_PER_AXIS = h4e_pkg::BITS_PER_AXIS_DEF,
  parameter int NUM_AXES = h4e_pkg::NUM_AXES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            coord_valid,
  output logic                 coord_stall,
  input  wire h4e_pkg::coord_t coord_x,
  input  wire h4e_pkg::coord_t coord_y,
  input  wire h4e_pkg::coord_t coord_z,
  input  wire h4e_pkg::coord_t coord_w,
  output logic                 index_valid,
  input  wire logic            index_stall,
  output h4e_pkg::index_t      curve_index
);
  import h4e_pkg::*;

  localparam int NUM_LEVELS = BITS_PER_AXIS - 1;

  coord_t                                 coords [MAX_AXES];
  logic [NUM_LEVELS:0]                    vld;
  logic [NUM_LEVELS:0]                    rdy;
  logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] ax [NUM_LEVELS+1];

  assign coords[0] = coord_x;
  assign coords[1] = coord_y;
  assign coords[2] = coord_z;
  assign coords[3] = coord_w;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      ax[0][i] = coords[i][BITS_PER_AXIS-1:0];
    end
  end

  assign vld[0] = coord_valid;
  assign coord_stall = !rdy[0];

  for (genvar k = 0; k < NUM_LEVELS; k++) begin : g_level
    h4e_level_cell #(
      .BITS_PER_AXIS(BITS_PER_AXIS),
      .NUM_AXES(NUM_AXES),
      .LEVEL(BITS_PER_AXIS - 1 - k)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .up_valid(vld[k]),
      .up_ready(rdy[k]),
      .up_ax(ax[k]),
      .dn_valid(vld[k+1]),
      .dn_stall(!rdy[k+1]),
      .dn_ax(ax[k+1])
    );
  end

  h4e_finish_cell #(
    .BITS_PER_AXIS(BITS_PER_AXIS),
    .NUM_AXES(NUM_AXES)
  ) u_finish (
    .clk(clk),
    .rst(rst),
    .up_valid(vld[NUM_LEVELS]),
    .up_ready(rdy[NUM_LEVELS]),
    .up_ax(ax[NUM_LEVELS]),
    .dn_valid(index_valid),
    .dn_stall(index_stall),
    .dn_index(curve_index)
  );
endmodule
`default_nettype wire

>>> rtl/h4e_level_cell.sv
// One bit level of the inverse-undo pass, registered, with valid/stall flow.
// Depends on h4e_pkg for the default geometry.
`timescale 1ns / 1ps
`default_nettype none
module h4e_level_cell #(
  parameter int BITS_PER_AXIS = h4e_pkg::BITS_PER_AXIS_DEF,
  parameter int NUM_AXES = h4e_pkg::NUM_AXES_DEF,
  parameter int LEVEL = h4e_pkg::BITS_PER_AXIS_DEF - 1
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    up_valid,
  output logic                                         up_ready,
  input  wire logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0]  up_ax,
  output logic                                         dn_valid,
  input  wire logic                                    dn_stall,
  output logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0]       dn_ax
);
  localparam logic [BITS_PER_AXIS-1:0] LOW = {BITS_PER_AXIS{1'b1}} >> (BITS_PER_AXIS - LEVEL);

  logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] ax_next;

  always_comb begin
    logic [BITS_PER_AXIS-1:0] sw;
    sw = '0;
    ax_next = up_ax;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (ax_next[i][LEVEL]) begin
        ax_next[0] = ax_next[0] ^ LOW;
      end else begin
        sw = (ax_next[0] ^ ax_next[i]) & LOW;
        ax_next[0] = ax_next[0] ^ sw;
        ax_next[i] = ax_next[i] ^ sw;
      end
    end
  end

  assign up_ready = !dn_valid || !dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_ax <= ax_next;
    end
  end
endmodule
`default_nettype wire

>>> rtl/h4e_finish_cell.sv
// Gray encode, correction mask and bit interleave into the output register.
// Depends on h4e_pkg for the index type.
`timescale 1ns / 1ps
`default_nettype none
module h4e_finish_cell #(
  parameter int BITS_PER_AXIS = h4e_pkg::BITS_PER_AXIS_DEF,
  parameter int NUM_AXES = h4e_pkg::NUM_AXES_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    up_valid,
  output logic                                         up_ready,
  input  wire logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0]  up_ax,
  output logic                                         dn_valid,
  input  wire logic                                    dn_stall,
  output h4e_pkg::index_t                              dn_index
);
  import h4e_pkg::*;

  logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] gray;
  logic [BITS_PER_AXIS-1:0]               fix;
  index_t                                 index_next;

  always_comb begin
    gray = up_ax;
    for (int i = 1; i < NUM_AXES; i++) begin
      gray[i] = gray[i] ^ gray[i-1];
    end
  end

  // fix bit j is the parity of the last axis above bit j
  always_comb begin
    for (int j = 0; j < BITS_PER_AXIS; j++) begin
      fix[j] = ^(gray[NUM_AXES-1] >> (j + 1));
    end
  end

  always_comb begin
    index_next = '0;
    for (int l = 0; l < BITS_PER_AXIS; l++) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        index_next[l*NUM_AXES + (NUM_AXES-1-i)] = gray[i][l] ^ fix[l];
      end
    end
  end

  assign up_ready = !dn_valid || !dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_index <= index_next;
    end
  end
endmodule
`default_nettype wire

>>> rtl/h4e_checker.sv
// Port-level checks for hilbert_4d_encode_core, attached by bind.
// Depends on h4e_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
module h4e_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            coord_valid,
  input wire logic            coord_stall,
  input wire logic            index_valid,
  input wire logic            index_stall,
  input wire h4e_pkg::index_t curve_index
);
  import h4e_pkg::*;

  // back-pressure on the input only when the chain is full up to a held result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    coord_stall |-> (index_valid && index_stall))
    else $error("input stalled without a held result");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !index_valid)
    else $error("result shown straight after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (index_valid && index_stall) |=> (index_valid && $stable(curve_index)))
    else $error("stalled result dropped or changed");

  a_free_input: assert property (@(posedge clk) disable iff (rst)
    !index_valid |-> !coord_stall)
    else $error("input stalled while output empty");
endmodule

bind hilbert_4d_encode_core h4e_checker u_h4e_checker (
  .clk(clk),
  .rst(rst),
  .coord_valid(coord_valid),
  .coord_stall(coord_stall),
  .index_valid(index_valid),
  .index_stall(index_stall),
  .curve_index(curve_index)
);
`default_nettype wire
